FILE: rtl/core/cdid_pkg.sv
// Shared widths, command codes and transaction types of the CD disc ID generator.
`timescale 1ns / 1ps
`default_nettype none

package cdid_pkg;

  localparam int unsigned FRAME_W = 19;
  localparam int unsigned TRACK_W = 7;
  localparam int unsigned ID_W    = 32;

  localparam logic CMD_TRACK   = 1'b0;
  localparam logic CMD_LEADOUT = 1'b1;

  typedef struct packed {
    logic               leadout;
    logic [FRAME_W-1:0] frame;
    logic [TRACK_W-1:0] track;
    logic               overflow;
  } cdid_op_t;

  typedef struct packed {
    logic [ID_W-1:0]    offset_id;
    logic [ID_W-1:0]    weighted_id;
    logic [ID_W-1:0]    cddb_id;
    logic [TRACK_W-1:0] track_total;
    logic               overflow;
  } cdid_result_t;

endpackage

`default_nettype wire

FILE: rtl/core/cdid_fifo.sv
// Small register queue with push/full and pop/empty sides.
`timescale 1ns / 1ps
`default_nettype none

module cdid_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/cdid_front.sv
// Front end: accepts offsets, numbers tracks, drops excess tracks and flags them.
`timescale 1ns / 1ps
`default_nettype none

module cdid_front #(
  parameter int unsigned MAX_TRACKS = 99,
  parameter int unsigned FRAME_BITS = 19
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  input  wire logic                          command_i,
  input  wire logic [cdid_pkg::FRAME_W-1:0]  frame_i,
  input  wire logic                          q_full_i,
  output logic                               q_push_o,
  output cdid_pkg::cdid_op_t                 q_op_o
);

  localparam logic [cdid_pkg::FRAME_W-1:0] FRAME_MASK =
    (FRAME_BITS >= cdid_pkg::FRAME_W) ? {cdid_pkg::FRAME_W{1'b1}}
                                      : cdid_pkg::FRAME_W'((64'd1 << FRAME_BITS) - 64'd1);

  logic [cdid_pkg::TRACK_W-1:0] tracks_q, tracks_d;
  logic                         ovf_q, ovf_d;
  logic                         accept;
  logic [cdid_pkg::FRAME_W-1:0] frame_m;

  assign accept  = push_i && !q_full_i;
  assign frame_m = frame_i & FRAME_MASK;

  always_comb begin
    tracks_d          = tracks_q;
    ovf_d             = ovf_q;
    q_push_o          = 1'b0;
    q_op_o.leadout    = 1'b0;
    q_op_o.frame      = frame_m;
    q_op_o.track      = tracks_q;
    q_op_o.overflow   = ovf_q;
    if (accept) begin
      if (command_i == cdid_pkg::CMD_LEADOUT) begin
        q_push_o       = 1'b1;
        q_op_o.leadout = 1'b1;
        tracks_d       = '0;
        ovf_d          = 1'b0;
      end else if (tracks_q >= cdid_pkg::TRACK_W'(MAX_TRACKS)) begin
        ovf_d = 1'b1;
      end else begin
        q_push_o     = 1'b1;
        tracks_d     = tracks_q + cdid_pkg::TRACK_W'(1);
        q_op_o.track = tracks_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tracks_q <= '0;
      ovf_q    <= 1'b0;
    end else begin
      tracks_q <= tracks_d;
      ovf_q    <= ovf_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/cdid_back.sv
// Back end: divide, digit-sum and product pipeline feeding the disc accumulators.
`timescale 1ns / 1ps
`default_nettype none

module cdid_back #(
  parameter int unsigned FRAMES_PER_SECOND = 75
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 q_empty_i,
  input  wire cdid_pkg::cdid_op_t   q_op_i,
  output logic                      q_pop_o,
  input  wire logic                 out_full_i,
  output logic                      out_push_o,
  output cdid_pkg::cdid_result_t    out_res_o
);

  localparam int unsigned FW         = cdid_pkg::FRAME_W;
  localparam int unsigned TW         = cdid_pkg::TRACK_W;
  localparam int unsigned IW         = cdid_pkg::ID_W;
  localparam int unsigned DIV_SHIFT  = FW + 8;
  localparam int unsigned DIV_MULT_W = DIV_SHIFT + 1;
  localparam logic [DIV_MULT_W-1:0] DIV_MULT = DIV_MULT_W'(
    ((64'd1 << DIV_SHIFT) + 64'(FRAMES_PER_SECOND) - 64'd1) / 64'(FRAMES_PER_SECOND));
  localparam int unsigned QPROD_W    = FW + DIV_MULT_W;
  localparam int unsigned WPROD_W    = FW + TW;
  localparam int unsigned VAL_W      = FW + 1;
  localparam int unsigned TEN_SHIFT  = VAL_W + 4;
  localparam int unsigned TEN_MULT_W = VAL_W + 1;
  localparam logic [TEN_MULT_W-1:0] TEN_MULT = TEN_MULT_W'(
    ((64'd1 << TEN_SHIFT) + 64'd9) / 64'd10);
  localparam int unsigned TPROD_W    = VAL_W + TEN_MULT_W;
  localparam int unsigned DIGIT_STAGES = 5;
  localparam int unsigned DSUM_W     = 6;
  localparam int unsigned DT_W       = 16;

  logic                       adv;

  logic                       a_vld_q;
  cdid_pkg::cdid_op_t         a_op_q;

  logic                       b_vld_q;
  cdid_pkg::cdid_op_t         b_op_q;
  logic [QPROD_W-1:0]         b_qprod_q, b_qprod_d;
  logic [WPROD_W-1:0]         b_wprod_q, b_wprod_d;
  logic [FW-1:0]              w_frame;
  logic [TW-1:0]              w_count;

  logic                       c_vld_q   [DIGIT_STAGES+1];
  cdid_pkg::cdid_op_t         c_op_q    [DIGIT_STAGES+1];
  logic [FW-1:0]              c_quo_q   [DIGIT_STAGES+1];
  logic [WPROD_W-1:0]         c_wprod_q [DIGIT_STAGES+1];
  logic [VAL_W-1:0]           c_val_q   [DIGIT_STAGES+1];
  logic [DSUM_W-1:0]          c_dsum_q  [DIGIT_STAGES+1];
  logic [TPROD_W-1:0]         t_prod    [DIGIT_STAGES];
  logic [VAL_W-1:0]           t_quo     [DIGIT_STAGES];
  logic [VAL_W-1:0]           t_rem     [DIGIT_STAGES];
  logic [FW-1:0]              c0_quo;

  logic [IW-1:0]              plain_q, plain_d;
  logic [IW-1:0]              weighted_q, weighted_d;
  logic [DT_W-1:0]            digit_q, digit_d;
  logic [FW-1:0]              first_q, first_d;
  logic [DSUM_W-1:0]          track_digits;
  logic [8:0]                 fold;
  logic [8:0]                 fold_red;
  logic [IW-1:0]              secs;
  cdid_pkg::cdid_op_t         z_op;
  logic                       z_fire;

  assign adv     = !out_full_i;
  assign q_pop_o = adv && !q_empty_i;

  always_comb begin
    w_frame   = a_op_q.frame;
    w_count   = a_op_q.track;
    if (a_op_q.leadout) begin
      w_count = a_op_q.track + TW'(1);
    end else if (a_op_q.frame == '0) begin
      w_frame = FW'(1);
    end
    b_wprod_d = WPROD_W'(w_frame) * WPROD_W'(w_count);
    b_qprod_d = QPROD_W'(a_op_q.frame) * QPROD_W'(DIV_MULT);
  end

  assign c0_quo = b_qprod_q[DIV_SHIFT +: FW];

  always_comb begin
    for (int k = 0; k < DIGIT_STAGES; k++) begin
      t_prod[k] = TPROD_W'(c_val_q[k]) * TPROD_W'(TEN_MULT);
      t_quo[k]  = t_prod[k][TEN_SHIFT +: VAL_W];
      t_rem[k]  = c_val_q[k] - ((t_quo[k] << 3) + (t_quo[k] << 1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      for (int k = 0; k <= DIGIT_STAGES; k++) begin
        c_vld_q[k] <= 1'b0;
      end
    end else if (adv) begin
      a_vld_q    <= q_pop_o;
      b_vld_q    <= a_vld_q;
      c_vld_q[0] <= b_vld_q;
      for (int k = 0; k < DIGIT_STAGES; k++) begin
        c_vld_q[k+1] <= c_vld_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_op_q       <= q_op_i;
      b_op_q       <= a_op_q;
      b_qprod_q    <= b_qprod_d;
      b_wprod_q    <= b_wprod_d;
      c_op_q[0]    <= b_op_q;
      c_quo_q[0]   <= c0_quo;
      c_wprod_q[0] <= b_wprod_q;
      c_val_q[0]   <= VAL_W'(c0_quo) + VAL_W'(2);
      c_dsum_q[0]  <= '0;
      for (int k = 0; k < DIGIT_STAGES; k++) begin
        c_op_q[k+1]    <= c_op_q[k];
        c_quo_q[k+1]   <= c_quo_q[k];
        c_wprod_q[k+1] <= c_wprod_q[k];
        c_val_q[k+1]   <= t_quo[k];
        c_dsum_q[k+1]  <= c_dsum_q[k] + DSUM_W'(t_rem[k][3:0]);
      end
    end
  end

  assign z_op   = c_op_q[DIGIT_STAGES];
  assign z_fire = adv && c_vld_q[DIGIT_STAGES];

  assign track_digits = c_dsum_q[DIGIT_STAGES] + DSUM_W'(c_val_q[DIGIT_STAGES][3:0]);
  assign fold         = {1'b0, digit_q[15:8]} + {1'b0, digit_q[7:0]};
  assign fold_red     = (fold >= 9'd510) ? fold - 9'd510 :
                        (fold >= 9'd255) ? fold - 9'd255 : fold;
  assign secs         = IW'(c_quo_q[DIGIT_STAGES]) - IW'(first_q);

  always_comb begin
    plain_d    = plain_q;
    weighted_d = weighted_q;
    digit_d    = digit_q;
    first_d    = first_q;
    out_push_o = 1'b0;
    out_res_o.offset_id   = plain_q + IW'(z_op.frame);
    out_res_o.weighted_id = weighted_q + IW'(c_wprod_q[DIGIT_STAGES]);
    out_res_o.cddb_id     = {fold_red[7:0], 24'd0} | (secs << 8) | IW'(z_op.track);
    out_res_o.track_total = z_op.track;
    out_res_o.overflow    = z_op.overflow;
    if (z_fire) begin
      if (z_op.leadout) begin
        out_push_o = 1'b1;
        plain_d    = '0;
        weighted_d = '0;
        digit_d    = '0;
        first_d    = '0;
      end else begin
        plain_d    = plain_q + IW'(z_op.frame);
        weighted_d = weighted_q + IW'(c_wprod_q[DIGIT_STAGES]);
        digit_d    = digit_q + DT_W'(track_digits);
        if (z_op.track == TW'(1)) begin
          first_d = c_quo_q[DIGIT_STAGES];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plain_q    <= '0;
      weighted_q <= '0;
      digit_q    <= '0;
      first_q    <= '0;
    end else begin
      plain_q    <= plain_d;
      weighted_q <= weighted_d;
      digit_q    <= digit_d;
      first_q    <= first_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/cd_disc_id_generator.sv
// Top level of the CD disc ID generator: front end, op queue, back end, result queue.
//
//   Channel | Direction | Handshake          | Payload
//   offsets | in        | push / full        | command_i, frame_i
//   results | out       | pop / empty        | offset_id_o, weighted_id_o, cddb_disc_id_o,
//           |           |                    | track_total_o, track_overflow_o
//
// One transaction is accepted per cycle when the queues keep flowing.
// A leadout result shows on the result ports after passing the op queue, the back end stages and the result queue.
// The back end pipeline has one divide stage and five decimal digit stages.
// Reset clears the track count, sums and queue pointers at once.
// A full result queue halts the back end; the four-entry op queue then fills and raises full.
`timescale 1ns / 1ps
`default_nettype none

module cd_disc_id_generator #(
  parameter int unsigned MAX_TRACKS        = 99,
  parameter int unsigned FRAMES_PER_SECOND = 75,
  parameter int unsigned FRAME_BITS        = 19
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic                         command_i,
  input  wire logic [cdid_pkg::FRAME_W-1:0] frame_i,
  output logic                              empty,
  input  wire logic                         pop,
  output logic [cdid_pkg::ID_W-1:0]         offset_id_o,
  output logic [cdid_pkg::ID_W-1:0]         weighted_id_o,
  output logic [cdid_pkg::ID_W-1:0]         cddb_disc_id_o,
  output logic [cdid_pkg::TRACK_W-1:0]      track_total_o,
  output logic                              track_overflow_o
);

  localparam int unsigned OP_DEPTH  = 4;
  localparam int unsigned RES_DEPTH = 2;

  logic                   fe_push;
  cdid_pkg::cdid_op_t     fe_op;
  logic                   op_full;
  logic                   op_empty;
  cdid_pkg::cdid_op_t     op_head;
  logic                   op_pop;
  logic                   res_full;
  logic                   res_push;
  cdid_pkg::cdid_result_t res_in;
  cdid_pkg::cdid_result_t res_head;

  assign full = op_full;

  cdid_front #(
    .MAX_TRACKS (MAX_TRACKS),
    .FRAME_BITS (FRAME_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .command_i (command_i),
    .frame_i   (frame_i),
    .q_full_i  (op_full),
    .q_push_o  (fe_push),
    .q_op_o    (fe_op)
  );

  cdid_fifo #(
    .WIDTH ($bits(cdid_pkg::cdid_op_t)),
    .DEPTH (OP_DEPTH)
  ) u_op_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_push),
    .wdata_i (fe_op),
    .full_o  (op_full),
    .pop_i   (op_pop),
    .rdata_o (op_head),
    .empty_o (op_empty)
  );

  cdid_back #(
    .FRAMES_PER_SECOND (FRAMES_PER_SECOND)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (op_empty),
    .q_op_i     (op_head),
    .q_pop_o    (op_pop),
    .out_full_i (res_full),
    .out_push_o (res_push),
    .out_res_o  (res_in)
  );

  cdid_fifo #(
    .WIDTH ($bits(cdid_pkg::cdid_result_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_head),
    .empty_o (empty)
  );

  assign offset_id_o      = res_head.offset_id;
  assign weighted_id_o    = res_head.weighted_id;
  assign cddb_disc_id_o   = res_head.cddb_id;
  assign track_total_o    = res_head.track_total;
  assign track_overflow_o = res_head.overflow;

  a_op_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fe_push |-> !op_full)
    else $error("Op queue written while full.");

  a_res_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("Result queue written while full.");

  a_track_low_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (cddb_disc_id_o[7:0] == 8'(track_total_o)))
    else $error("Disc ID low byte differs from the track count.");

  a_overflow_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && track_overflow_o) |-> (track_total_o == cdid_pkg::TRACK_W'(MAX_TRACKS)))
    else $error("Overflow flagged with fewer than the maximum tracks.");

endmodule

`default_nettype wire
